### design/sliding_window_notice_limiter_assert.svh
// Assertion macros used by the limiter RTL.
`ifndef SLIDING_WINDOW_NOTICE_LIMITER_ASSERT_SVH
`define SLIDING_WINDOW_NOTICE_LIMITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWNL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("limiter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWNL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("limiter check failed");

`endif

### design/swnl_pkg.sv
package swnl_pkg;

	localparam int TIME_W       = 32;
	localparam int MAX_EV_W     = 5;
	localparam int TALLY_W      = 16;
	localparam int RING_DEPTH_DEF = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENTS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 1'd1;

	localparam logic [MAX_EV_W-1:0] MAX_EVENTS_RST = 5'd20;
	localparam logic [TIME_W-1:0]   WINDOW_RST     = 32'd5000;
	localparam logic [TALLY_W-1:0]  TALLY_MAX      = {TALLY_W{1'b1}};

	// One stored timestamp and whether it is live.
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] stamp;
	} swnl_link_t;

endpackage

### design/swnl_cell.sv
module swnl_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift_en,
	input  logic [swnl_pkg::TIME_W-1:0] event_time,
	input  logic [swnl_pkg::TIME_W-1:0] window_ticks,
	input  swnl_pkg::swnl_link_t       link_in,
	input  logic                       keep_in,
	output logic                       keep_out,
	output swnl_pkg::swnl_link_t       link_q
);
	import swnl_pkg::*;

	logic [TIME_W-1:0] age;
	logic              in_window;

	// The stamp arriving from the newer neighbor is judged against the new time.
	assign age       = event_time - link_in.stamp;
	assign in_window = link_in.valid && (age <= window_ticks);
	// A stamp survives if it, or any older stamp, is still inside the window.
	assign keep_out  = in_window || keep_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else if (shift_en) begin
			link_q.valid <= keep_out;
			link_q.stamp <= link_in.stamp;
		end
	end

endmodule

### design/sliding_window_notice_limiter.sv
// Sliding-window event limiter. Each transaction on the input channel carries
// a 32-bit timestamp; the block answers with exactly one result transaction
// telling whether the event passed and, for a passing event, how many events
// were suppressed since the previous pass. The recent timestamps sit in a row
// of RING_DEPTH cells that shift by one place on every accepted transaction,
// newest in cell 0, so a full row simply drops its oldest stamp off the end.
// All cells test their stamp against the new time in parallel, so the
// block takes one transaction per clock unless the output stalls, and the
// result is registered at the accepting edge; the clock period is set by the
// single wrap-safe subtract and compare per cell plus the OR chain from the
// oldest cell toward the newest. The output register lets a new one in while
// the previous result is being taken, and the input stalls only while a result
// waits and the output is stalled. The stamp store needs no clearing pass:
// every cell carries its own valid bit, cleared by reset. Write the
// configuration registers (index 0 max_events, index 1 window_ticks) only when
// no result is pending.
module sliding_window_notice_limiter #(
	parameter int RING_DEPTH = swnl_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [swnl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swnl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [swnl_pkg::TIME_W-1:0]     event_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           passed,
	output logic [swnl_pkg::TALLY_W-1:0]    suppressed_before
);
	import swnl_pkg::*;

	// Wide enough to compare max_events against any cell position.
	localparam int CW = $clog2(RING_DEPTH + (1 << MAX_EV_W)) + 1;

	logic [MAX_EV_W-1:0] max_events_q;
	logic [TIME_W-1:0]   window_ticks_q;
	logic [TALLY_W-1:0]  tally_q;
	logic                out_valid_q;
	logic                passed_q;
	logic [TALLY_W-1:0]  suppressed_q;

	logic                 in_accept;
	logic                 over_limit;
	logic [RING_DEPTH:0]  keep_chain;
	logic [RING_DEPTH-1:0] cell_valid;
	swnl_link_t           cell_q [RING_DEPTH];

	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_events_q   <= MAX_EVENTS_RST;
			window_ticks_q <= WINDOW_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_MAX_EVENTS:   max_events_q   <= cfg_data[MAX_EV_W-1:0];
				CFG_WINDOW_TICKS: window_ticks_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Nothing is older than the oldest cell, so the chain starts empty there.
	assign keep_chain[RING_DEPTH] = 1'b0;

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		swnl_link_t link_in;

		if (i == 0) begin : g_head
			assign link_in = '{valid: 1'b1, stamp: event_time};
		end else begin : g_body
			assign link_in = cell_q[i-1];
		end

		swnl_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.shift_en     (in_accept),
			.event_time   (event_time),
			.window_ticks (window_ticks_q),
			.link_in      (link_in),
			.keep_in      (keep_chain[i+1]),
			.keep_out     (keep_chain[i]),
			.link_q       (cell_q[i])
		);

		assign cell_valid[i] = cell_q[i].valid;
	end

	// Surviving stamps fill cells 0 upward, so more than max_events of them
	// survive exactly when the cell at position max_events survives. A row no
	// deeper than max_events can never go over the limit.
	always_comb begin
		over_limit = 1'b0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			if (CW'(max_events_q) == CW'(i)) begin
				over_limit = keep_chain[i];
			end
		end
	end

	// Suppression tally and output handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				out_valid_q <= 1'b1;
				if (over_limit) begin
					if (tally_q != TALLY_MAX) begin
						tally_q <= tally_q + 1'b1;
					end
				end else begin
					tally_q <= '0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			passed_q     <= !over_limit;
			suppressed_q <= over_limit ? '0 : tally_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign passed            = passed_q;
	assign suppressed_before = suppressed_q;

`include "sliding_window_notice_limiter_assert.svh"

	// Live stamps always occupy a contiguous run starting at the newest cell.
	`SWNL_ASSERT_NOW(a_cells_contiguous, clk, arst_n, 1'b1, (cell_valid & (cell_valid + 1'b1)) == '0)
	// The newest stamp is always inside its own window.
	`SWNL_ASSERT_NEXT(a_newest_kept, clk, arst_n, in_accept, cell_valid[0])
	// A suppressed result never reports a count.
	`SWNL_ASSERT_NOW(a_suppressed_zero, clk, arst_n, out_valid_q && !passed_q, suppressed_q == '0)
	// A passing event clears the tally.
	`SWNL_ASSERT_NEXT(a_pass_clears, clk, arst_n, in_accept && !over_limit, tally_q == '0)

endmodule

### verif/swnl_checker.sv
module swnl_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [swnl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swnl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [swnl_pkg::TIME_W-1:0]     event_time,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            passed,
	input  logic [swnl_pkg::TALLY_W-1:0]    suppressed_before,
	output int                              mismatch_count,
	output int                              pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import swnl_pkg::*;

	typedef struct packed {
		logic               passed;
		logic [TALLY_W-1:0] suppressed_before;
	} outcome_t;

	// Shadow of the limiter: the stamps still inside the window, oldest first.
	logic [TIME_W-1:0]   live_stamps[$];
	outcome_t            outcomes_due[$];
	logic [MAX_EV_W-1:0] limit_events;
	logic [TIME_W-1:0]   limit_window;
	logic [TALLY_W-1:0]  held_tally;
	int                  failures;

	function automatic outcome_t judge_event(input logic [TIME_W-1:0] now);
		outcome_t verdict;
		if (live_stamps.size() == RING_DEPTH_DEF)
			void'(live_stamps.pop_front());
		live_stamps.push_back(now);
		// The age is taken modulo 2^32, so the window holds across a wrap.
		while (live_stamps.size() > 0 && (now - live_stamps[0]) > limit_window)
			void'(live_stamps.pop_front());
		if (live_stamps.size() > limit_events) begin
			if (held_tally != TALLY_MAX)
				held_tally++;
			verdict.passed            = 1'b0;
			verdict.suppressed_before = '0;
		end else begin
			verdict.passed            = 1'b1;
			verdict.suppressed_before = held_tally;
			held_tally                = '0;
		end
		return verdict;
	endfunction

	task automatic note_failure(input string what, input outcome_t want, input outcome_t got);
		if (failures < 10)
			$display("%0t: %s: want passed=%0d supp=%0d, got passed=%0d supp=%0d",
				$time, what, want.passed, want.suppressed_before, got.passed,
				got.suppressed_before);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			live_stamps.delete();
			outcomes_due.delete();
			limit_events = MAX_EVENTS_RST;
			limit_window = WINDOW_RST;
			held_tally   = '0;
			failures     = 0;
			mismatch_count <= 0;
			pending_count  <= 0;
		end else begin
			if (cfg_write_en) begin
				if (cfg_index == CFG_MAX_EVENTS)
					limit_events = cfg_data[MAX_EV_W-1:0];
				else if (cfg_index == CFG_WINDOW_TICKS)
					limit_window = cfg_data[TIME_W-1:0];
			end
			// A result can only belong to an event taken at an earlier edge,
			// so it is matched before this edge's event is judged.
			if (out_valid && !out_stall) begin
				got.passed            = passed;
				got.suppressed_before = suppressed_before;
				if (outcomes_due.size() == 0) begin
					note_failure("result with no event outstanding", '0, got);
				end else begin
					want = outcomes_due.pop_front();
					if (got !== want)
						note_failure("result mismatch", want, got);
				end
			end
			if (in_valid && !in_stall)
				outcomes_due.push_back(judge_event(event_time));
			mismatch_count <= failures;
			pending_count  <= outcomes_due.size();
		end
	end

endmodule

### verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import swnl_pkg::*;

	// The watchdog gives up after this many cycles without any transaction on
	// either channel. The slowest legal stretch is a sender gap, a receiver
	// stall run and a pair of configuration writes, all far below this.
	localparam int QUIET_LIMIT     = 2000;
	localparam int SUPPRESS_EVENTS = 40;
	localparam int RANDOM_PHASES   = 10;
	localparam int PHASE_EVENTS    = 145;
	localparam int TAIL_CYCLES     = 5;

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_RUNS,
		STALL_RARE
	} stall_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [TIME_W-1:0]     event_time;
	logic                  out_valid;
	logic                  out_stall;
	logic                  passed;
	logic [TALLY_W-1:0]    suppressed_before;

	int mismatch_count;
	int pending_count;
	int quiet_cycles = 0;
	int burst_left   = 0;

	sliding_window_notice_limiter DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.event_time        (event_time),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.passed            (passed),
		.suppressed_before (suppressed_before)
	);

	swnl_checker checker_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.event_time        (event_time),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.passed            (passed),
		.suppressed_before (suppressed_before),
		.mismatch_count    (mismatch_count),
		.pending_count     (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The receiver switches between stall patterns at random points:
	// no stalls at all, a coin toss per cycle, long runs of stall and ready,
	// and an occasional single stall. That way stalls land on every phase of
	// the output register, including the cycle a new transaction comes in.
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          run_left   = 0;
	logic        run_stall  = 1'b0;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_RARE));
			mode_left  = $urandom_range(20, 300);
		end
		mode_left--;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
			STALL_RUNS: begin
				if (run_left == 0) begin
					run_stall = !run_stall;
					run_left  = run_stall ? $urandom_range(1, 12) : $urandom_range(1, 6);
				end
				run_left--;
				out_stall <= run_stall;
			end
			default: out_stall <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Any transaction on either channel resets the quiet count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// Offers one event and returns at the edge where it is taken. The sender
	// runs in bursts; a fresh burst may start after a gap with valid low.
	task automatic post_event(input logic [TIME_W-1:0] stamp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		event_time <= stamp;
		@(posedge clk iff (in_valid && !in_stall));
	endtask

	// Holds the sender off until every result is back. The first edge lets
	// the checker count the event taken at the edge we were called from.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		@(posedge clk);
	endtask

	// Both registers are rewritten, one after the other, and only once the block is idle.
	task automatic load_limits(input logic [MAX_EV_W-1:0] events_allowed,
		input logic [TIME_W-1:0] window);
		drain_results();
		cfg_write_en <= 1'b1;
		cfg_index    <= CFG_MAX_EVENTS;
		cfg_data     <= CFG_DATA_W'(events_allowed);
		@(posedge clk);
		cfg_index <= CFG_WINDOW_TICKS;
		cfg_data  <= window;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	initial begin
		logic [MAX_EV_W-1:0] events_allowed;
		logic [TIME_W-1:0]   window;
		logic [TIME_W-1:0]   clock_now;
		int unsigned         span;
		int unsigned         divisor;

		arst_n       <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index    <= CFG_MAX_EVENTS;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		event_time   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits first: the second stamp is almost a full wrap away, so
		// the first one falls out of the window.
		post_event(32'h0000_0000);
		post_event(32'hFFFF_FFFF);

		// Two events per ten ticks, with stamps running across the wrap. The
		// third, fourth and fifth are suppressed, the one at 20 clears the
		// window and reports three, and the one at 5 runs backwards, so every
		// older stamp looks very old and is dropped.
		load_limits(5'd2, 32'd10);
		post_event(32'hFFFF_FFF8);
		post_event(32'hFFFF_FFFC);
		post_event(32'hFFFF_FFFF);
		post_event(32'h0000_0000);
		post_event(32'h0000_0002);
		post_event(32'h0000_0014);
		post_event(32'h0000_0005);

		// With zero allowed every event is suppressed, even in an empty window.
		load_limits(5'd0, 32'hFFFF_FFFF);
		post_event(32'h0000_0064);
		post_event(32'h8000_0000);
		post_event(32'hFFFF_FFFF);

		// A zero window keeps only stamps equal to the current time.
		load_limits(5'd31, 32'd0);
		post_event(32'h0000_0007);
		post_event(32'h0000_0007);
		post_event(32'h0000_0007);

		// Hold the limit at zero for a run of events so the suppressed count
		// builds up, then allow one: the first event through reports the
		// count, an equal stamp right after it is suppressed again, and the
		// next tick passes and reports one.
		load_limits(5'd0, 32'd1000);
		for (int i = 0; i < SUPPRESS_EVENTS; i++)
			post_event(TIME_W'(i));
		load_limits(5'd1, 32'd0);
		post_event(32'h8000_0000);
		post_event(32'h8000_0000);
		post_event(32'h8000_0001);

		// Random phases. Most stamps advance monotonically in steps sized so
		// the window holds about as many stamps as are allowed, which keeps the
		// limiter switching between passing and suppressing and fills the ring
		// when the window is wide. One stamp in ten is an arbitrary value.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 9))
				0:       events_allowed = 5'd0;
				1:       events_allowed = 5'd1;
				2:       events_allowed = 5'd31;
				default: events_allowed = MAX_EV_W'($urandom_range(1, 31));
			endcase
			case ($urandom_range(0, 9))
				0:       window = 32'd0;
				1:       window = 32'hFFFF_FFFF;
				2:       window = $urandom;
				default: window = $urandom_range(1, 3000);
			endcase
			load_limits(events_allowed, window);

			span      = (window > 4000) ? 4000 : window;
			divisor   = (events_allowed == 0) ? 1 : events_allowed;
			clock_now = ($urandom_range(0, 3) == 0) ?
				32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;

			for (int n = 0; n < PHASE_EVENTS; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					post_event($urandom);
				end else begin
					clock_now += $urandom_range(0, (2 * span) / divisor + 1);
					post_event(clock_now);
				end
				// Now and then the sender waits for every result to return.
				if ($urandom_range(0, 63) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
